// File: hw/rtl/vpa_pkg.sv
// vpa_pkg: shared types and constants for the variable partition allocator
// used by vpa_front, vpa_back and variable_partition_allocator_unit
`default_nettype none
package vpa_pkg;
  localparam int AddrW = 15;
  localparam int DefPoolSize = 32767;
  localparam int DefMaxExtents = 64;

  localparam logic CmdAlloc   = 1'b0;
  localparam logic CmdRelease = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] base_address;
    logic [AddrW-1:0] length;
    logic             zero_len;
    logic             past_end;
  } req_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SCAN, B_DECIDE, B_SHIFT_DN, B_SHIFT_UP, B_LARGEST, B_OUT
  } bstate_t;
endpackage
`default_nettype wire

// File: hw/rtl/vpa_front.sv
// vpa_front: accepts request transactions, flags trivial rejects, queues them
// depends on vpa_pkg
`default_nettype none
module vpa_front
  import vpa_pkg::*;
#(
  parameter int PoolSize = DefPoolSize
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             cmd,
  input  wire logic [AddrW-1:0] base_address,
  input  wire logic [AddrW-1:0] length,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output req_t                  q_req
);
  // two entry queue
  req_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic [AddrW:0] req_end;
  req_t       incoming;

  assign req_end  = {1'b0, base_address} + {1'b0, length};
  always_comb begin
    incoming.cmd          = cmd;
    incoming.base_address = base_address;
    incoming.length       = length;
    incoming.zero_len     = (length == '0);
    incoming.past_end     = (req_end > (AddrW+1)'(PoolSize));
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill overflow");
  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 && !(in_valid && in_ready)) |=> !q_valid)
    else $error("queue valid without entry");
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready && !(in_valid && in_ready)) |=> q_valid)
    else $error("queue entry lost");
endmodule
`default_nettype wire

// File: hw/rtl/vpa_back.sv
// vpa_back: extent table engine, scans, edits the table and forms results
// depends on vpa_pkg
`default_nettype none
module vpa_back
  import vpa_pkg::*;
#(
  parameter int MaxExtents = DefMaxExtents,
  parameter int PoolSize   = DefPoolSize
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fit_mode,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  req_t                  q_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            status,
  output logic [AddrW-1:0]      granted_address,
  output logic [AddrW-1:0]      largest_free
);
  localparam int IdxW = $clog2(MaxExtents);
  localparam int CntW = $clog2(MaxExtents + 1);

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
  } extent_t;

  // extent table, one write port and one registered read port
  extent_t          etab [MaxExtents];
  extent_t          rd_data;
  logic             tab_we;
  logic [IdxW-1:0]  tab_waddr, tab_raddr;
  extent_t          tab_wdata;

  logic [CntW-1:0]  count;
  bstate_t          state, state_next;
  req_t             req;
  logic [CntW-1:0]  idx, rd_idx, pos, pick;
  logic             rd_vld, found, overlap, pos_found;
  logic [AddrW-1:0] pick_len, pick_base, best;
  logic [AddrW-1:0] largest_run;
  logic [2:0]       st;
  logic [AddrW-1:0] grant;
  extent_t          last_ext, succ_ext;

  logic             in_range, scan_done, more_up;
  logic [AddrW:0]   cur_end, req_end, pred_end;
  logic             has_pred, has_succ;

  status_t          dec_st;
  bstate_t          dec_next;
  logic [CntW-1:0]  dec_idx;
  logic             dec_we;
  logic [IdxW-1:0]  dec_waddr;
  extent_t          dec_wdata;

  assign in_range  = (idx < count);
  assign scan_done = !in_range && !rd_vld;
  assign more_up   = (idx > pos);
  assign tab_raddr = (state == B_SHIFT_UP) ? IdxW'(idx - CntW'(1)) : idx[IdxW-1:0];
  assign cur_end   = {1'b0, rd_data.base} + {1'b0, rd_data.len};
  assign req_end   = {1'b0, req.base_address} + {1'b0, req.length};

  // last_ext is the entry below the insertion point, succ_ext the one at it
  assign pred_end = {1'b0, last_ext.base} + {1'b0, last_ext.len};
  assign has_pred = (pos != '0) && (pred_end == {1'b0, req.base_address});
  assign has_succ = pos_found && ({1'b0, succ_ext.base} == req_end);

  always_comb begin
    dec_st    = ST_RELEASED;
    dec_next  = B_LARGEST;
    dec_idx   = '0;
    dec_we    = 1'b0;
    dec_waddr = '0;
    dec_wdata = '0;
    if (req.cmd == CmdAlloc) begin
      if (req.zero_len || !found) begin
        dec_st = ST_NO_FIT;
      end else begin
        dec_st = ST_ALLOCATED;
        if (pick_len == req.length) begin
          dec_next = B_SHIFT_DN;
          dec_idx  = pick + CntW'(1);
        end else begin
          dec_we         = 1'b1;
          dec_waddr      = pick[IdxW-1:0];
          dec_wdata.base = pick_base + req.length;
          dec_wdata.len  = pick_len - req.length;
        end
      end
    end else if (req.zero_len || req.past_end || overlap) begin
      dec_st = ST_REJECTED;
    end else if (has_pred && has_succ) begin
      dec_we         = 1'b1;
      dec_waddr      = IdxW'(pos - CntW'(1));
      dec_wdata.base = last_ext.base;
      dec_wdata.len  = last_ext.len + req.length + succ_ext.len;
      dec_next       = B_SHIFT_DN;
      dec_idx        = pos + CntW'(1);
    end else if (has_pred) begin
      dec_we         = 1'b1;
      dec_waddr      = IdxW'(pos - CntW'(1));
      dec_wdata.base = last_ext.base;
      dec_wdata.len  = last_ext.len + req.length;
    end else if (has_succ) begin
      dec_we         = 1'b1;
      dec_waddr      = pos[IdxW-1:0];
      dec_wdata.base = req.base_address;
      dec_wdata.len  = succ_ext.len + req.length;
    end else if (count >= CntW'(MaxExtents)) begin
      dec_st = ST_FULL;
    end else begin
      dec_next = B_SHIFT_UP;
      dec_idx  = count;
    end
  end

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = '0;
    tab_wdata = '0;
    if (rst) begin
      tab_we         = 1'b1;
      tab_wdata.base = '0;
      tab_wdata.len  = AddrW'(PoolSize);
    end else begin
      case (state)
        B_DECIDE: begin
          tab_we    = dec_we;
          tab_waddr = dec_waddr;
          tab_wdata = dec_wdata;
        end
        B_SHIFT_DN: begin
          if (rd_vld) begin
            tab_we    = 1'b1;
            tab_waddr = IdxW'(rd_idx - CntW'(1));
            tab_wdata = rd_data;
          end
        end
        B_SHIFT_UP: begin
          if (rd_vld) begin
            tab_we    = 1'b1;
            tab_waddr = IdxW'(rd_idx + CntW'(1));
            tab_wdata = rd_data;
          end else if (!more_up) begin
            tab_we         = 1'b1;
            tab_waddr      = pos[IdxW-1:0];
            tab_wdata.base = req.base_address;
            tab_wdata.len  = req.length;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) etab[tab_waddr] <= tab_wdata;
    rd_data <= etab[tab_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:     if (q_valid) state_next = B_SCAN;
      B_SCAN:     if (scan_done) state_next = B_DECIDE;
      B_DECIDE:   state_next = dec_next;
      B_SHIFT_DN: if (scan_done) state_next = B_LARGEST;
      B_SHIFT_UP: if (!more_up && !rd_vld) state_next = B_LARGEST;
      B_LARGEST:  if (scan_done) state_next = B_OUT;
      B_OUT:      if (out_ready) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready         = (state == B_IDLE);
    out_valid       = (state == B_OUT);
    status          = st;
    granted_address = grant;
    largest_free    = largest_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      count  <= CntW'(1);
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            req       <= q_req;
            idx       <= '0;
            rd_vld    <= 1'b0;
            found     <= 1'b0;
            overlap   <= 1'b0;
            pos       <= count;
            pos_found <= 1'b0;
          end
        end
        B_SCAN: begin
          rd_vld <= in_range;
          rd_idx <= idx;
          if (in_range) idx <= idx + CntW'(1);
          if (rd_vld) begin
            if (req.cmd == CmdAlloc) begin
              if (rd_data.len >= req.length &&
                  (!found || (fit_mode && rd_data.len < pick_len))) begin
                found     <= 1'b1;
                pick      <= rd_idx;
                pick_len  <= rd_data.len;
                pick_base <= rd_data.base;
              end
            end else begin
              if ({1'b0, req.base_address} < cur_end && {1'b0, rd_data.base} < req_end)
                overlap <= 1'b1;
              if (!pos_found) begin
                if (rd_data.base > req.base_address) begin
                  pos_found <= 1'b1;
                  pos       <= rd_idx;
                  succ_ext  <= rd_data;
                end else begin
                  last_ext <= rd_data;
                end
              end
            end
          end
        end
        B_DECIDE: begin
          st     <= dec_st;
          grant  <= (dec_st == ST_ALLOCATED) ? pick_base : '0;
          idx    <= dec_idx;
          rd_vld <= 1'b0;
          best   <= '0;
        end
        B_SHIFT_DN: begin
          rd_vld <= in_range;
          rd_idx <= idx;
          if (in_range) idx <= idx + CntW'(1);
          if (scan_done) begin
            count <= count - CntW'(1);
            idx   <= '0;
          end
        end
        B_SHIFT_UP: begin
          rd_vld <= more_up;
          rd_idx <= idx - CntW'(1);
          if (more_up) begin
            idx <= idx - CntW'(1);
          end else if (!rd_vld) begin
            count <= count + CntW'(1);
            idx   <= '0;
          end
        end
        B_LARGEST: begin
          rd_vld <= in_range;
          if (in_range) idx <= idx + CntW'(1);
          if (rd_vld && rd_data.len > best) best <= rd_data.len;
          if (scan_done) largest_run <= best;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(MaxExtents))
    else $error("extent count beyond table");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL)
    else $error("bad status");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ALLOCATED) |-> granted_address == '0)
    else $error("grant without allocation");
  assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && !out_ready) |=> state == B_OUT)
    else $error("result dropped");
endmodule
`default_nettype wire

// File: hw/rtl/variable_partition_allocator_unit.sv
// variable_partition_allocator_unit: top level of the extent allocator
// depends on vpa_pkg, vpa_front, vpa_back
`default_nettype none
// Free extent allocator over one pool. Each request transaction (tdata from bit 0:
// cmd, base_address, length) gives one result transaction (tdata from bit 0:
// status, granted_address, largest_free). A front queue of two entries takes
// requests while the back engine works; the engine reads the extent table one
// entry a cycle through a registered read port. It scans the free extents once to
// decide and once more for largest_free, and shifts the table entries when an
// entry is removed or inserted.
module variable_partition_allocator_unit
  import vpa_pkg::*;
#(
  parameter int PoolSize   = DefPoolSize,
  parameter int MaxExtents = DefMaxExtents
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // cmd, base_address, length
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // status, granted_address, largest_free
);
  logic             fit_mode;
  logic             q_valid, q_ready;
  req_t             q_req;
  logic [2:0]       status;
  logic [AddrW-1:0] granted_address, largest_free;

  always_ff @(posedge clk) begin
    if (rst) fit_mode <= 1'b0;
    else if (cfg_we) fit_mode <= cfg_wdata[0];
  end

  vpa_front #(.PoolSize(PoolSize)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tdata[0]), .base_address(s_axis_tdata[15:1]),
    .length(s_axis_tdata[30:16]),
    .q_valid, .q_ready, .q_req
  );

  vpa_back #(.MaxExtents(MaxExtents), .PoolSize(PoolSize)) u_back (
    .clk, .rst, .fit_mode,
    .q_valid, .q_ready, .q_req,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .status, .granted_address, .largest_free
  );

  assign m_axis_tdata = {7'd0, largest_free, granted_address, status};
endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for variable_partition_allocator_unit
// predicts every result from a local free-extent table; depends on vpa_pkg and the rtl
`timescale 1ns / 100ps
module testbench;
  import vpa_pkg::*;

  localparam int Pool = DefPoolSize;
  localparam int Slots = DefMaxExtents;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [AddrW-1:0] length;
    logic [AddrW-1:0] base_address;
    logic             cmd;
  } request_t;

  typedef struct packed {
    logic [AddrW-1:0] largest_free;
    logic [AddrW-1:0] granted_address;
    status_t          status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  variable_partition_allocator_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // local copy of the free table
  int ext_base[Slots];
  int ext_len[Slots];
  int ext_count;
  bit best_fit;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 54;
  int hold_off = 0;

  // state helper for the result predictor
  function automatic void drop_extent(int k);
    for (int i = k; i + 1 < ext_count; i++) begin
      ext_base[i] = ext_base[i + 1];
      ext_len[i] = ext_len[i + 1];
    end
    ext_count--;
  endfunction

  function automatic answer_t predict_allocator(request_t r);
    answer_t a;
    int pick, e, pos, m;
    bit found, pred, succ;
    a.status = ST_NO_FIT;
    a.granted_address = '0;
    if (r.cmd == CmdAlloc) begin
      found = 0;
      pick = 0;
      if (r.length != 0) begin
        for (int i = 0; i < ext_count; i++) begin
          if (ext_len[i] < r.length) continue;
          if (!found || (best_fit && ext_len[i] < ext_len[pick])) begin
            pick = i;
            found = 1;
            if (!best_fit) break;
          end
        end
      end
      if (found) begin
        a.status = ST_ALLOCATED;
        a.granted_address = ext_base[pick][AddrW-1:0];
        if (ext_len[pick] == r.length) drop_extent(pick);
        else begin
          ext_base[pick] += r.length;
          ext_len[pick] -= r.length;
        end
      end
    end else begin
      e = r.base_address + r.length;
      a.status = ST_RELEASED;
      if (r.length == 0 || e > Pool) a.status = ST_REJECTED;
      for (int i = 0; i < ext_count; i++)
        if (r.base_address < ext_base[i] + ext_len[i] && ext_base[i] < e)
          a.status = ST_REJECTED;
      if (a.status == ST_RELEASED) begin
        pos = ext_count;
        for (int i = ext_count - 1; i >= 0; i--)
          if (ext_base[i] > r.base_address) pos = i;
        pred = pos > 0 && ext_base[pos - 1] + ext_len[pos - 1] == r.base_address;
        succ = pos < ext_count && ext_base[pos] == e;
        if (pred && succ) begin
          ext_len[pos - 1] += r.length + ext_len[pos];
          drop_extent(pos);
        end else if (pred) ext_len[pos - 1] += r.length;
        else if (succ) begin
          ext_base[pos] = r.base_address;
          ext_len[pos] += r.length;
        end else if (ext_count >= Slots) a.status = ST_FULL;
        else begin
          for (int i = ext_count; i > pos; i--) begin
            ext_base[i] = ext_base[i - 1];
            ext_len[i] = ext_len[i - 1];
          end
          ext_base[pos] = r.base_address;
          ext_len[pos] = r.length;
          ext_count++;
        end
      end
    end
    m = 0;
    for (int i = 0; i < ext_count; i++) if (ext_len[i] > m) m = ext_len[i];
    a.largest_free = m[AddrW-1:0];
    return a;
  endfunction

  // granted regions kept by the stimulus side so that releases are mostly legal
  int held_base[$];
  int held_len[$];

  function automatic request_t make_req(bit c, int b, int l);
    request_t r;
    r.cmd = c;
    r.base_address = b[AddrW-1:0];
    r.length = l[AddrW-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_answers.push_back(predict_allocator(request_t'(s_axis_tdata[30:0])));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, pending_requests.pop_front()};
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = answer_t'(m_axis_tdata[32:0]);
        if (expected_answers.size() == 0) begin
          $error("result with none expected: %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.granted_address !== want.granted_address) begin
            $error("granted_address expected %0d actual %0d", want.granted_address,
                   got.granted_address);
            errors++;
          end
          if (got.largest_free !== want.largest_free) begin
            $error("largest_free expected %0d actual %0d", want.largest_free,
                   got.largest_free);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_fit_mode(bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= {7'($urandom_range(127)), v};
    best_fit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly allocate/release pairs of held regions, some noise
  task automatic queue_random(int n);
    int k, b, l;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          l = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(1, 600);
          pending_requests.push_back(make_req(CmdAlloc, $urandom_range(32767), l));
        end
        4, 5, 6, 7: begin
          if (held_base.size() > 0) begin
            k = $urandom_range(held_base.size() - 1);
            b = held_base[k];
            l = held_len[k];
            held_base.delete(k);
            held_len.delete(k);
            pending_requests.push_back(make_req(CmdRelease, b, l));
          end
        end
        default: pending_requests.push_back(make_req(CmdRelease, $urandom_range(32767),
                                                     $urandom_range(32767)));
      endcase
    end
  endtask

  // predictor shadows state only at acceptance, so track grants by a synthetic split:
  // releases of held regions use pieces cut from known allocations below
  task automatic queue_pieces(int n, int sz);
    for (int i = 0; i < n; i++) begin
      held_base.push_back(i * sz);
      held_len.push_back(sz);
    end
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      ext_base[i] = 0;
      ext_len[i] = 0;
    end
    ext_len[0] = Pool;
    ext_count = 1;
    best_fit = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero lengths, overlaps, past end, merges both sides
    pending_requests.push_back(make_req(CmdAlloc, 0, 0));
    pending_requests.push_back(make_req(CmdRelease, 5, 0));
    pending_requests.push_back(make_req(CmdRelease, 32767, 32767));
    pending_requests.push_back(make_req(CmdRelease, 100, 10));
    pending_requests.push_back(make_req(CmdAlloc, 32767, 32767));
    pending_requests.push_back(make_req(CmdAlloc, 0, 1));
    pending_requests.push_back(make_req(CmdRelease, 0, 32767));
    pending_requests.push_back(make_req(CmdRelease, 0, 32767));
    pending_requests.push_back(make_req(CmdAlloc, 0, 100));
    pending_requests.push_back(make_req(CmdAlloc, 0, 100));
    pending_requests.push_back(make_req(CmdAlloc, 0, 100));
    pending_requests.push_back(make_req(CmdRelease, 0, 100));
    pending_requests.push_back(make_req(CmdRelease, 200, 100));
    pending_requests.push_back(make_req(CmdRelease, 100, 100));
    pending_requests.push_back(make_req(CmdAlloc, 0, 32767));
    pending_requests.push_back(make_req(CmdRelease, 32766, 1));
    pending_requests.push_back(make_req(CmdRelease, 0, 16384));
    pending_requests.push_back(make_req(CmdRelease, 16384, 16382));
    pending_requests.push_back(make_req(CmdAlloc, 0, 32767));
    wait_drained();

    // fill the table with 100-unit holes: every other slice released
    set_fit_mode(1'b1);
    for (int i = 0; i < 150; i++)
      pending_requests.push_back(make_req(CmdRelease, i * 200 + ($urandom_range(1) * 100), 100));
    pending_requests.push_back(make_req(CmdAlloc, 0, 50));
    pending_requests.push_back(make_req(CmdAlloc, 0, 101));
    hold_off = 3000;
    wait_drained();
    pending_requests.push_back(make_req(CmdAlloc, 0, 32767));
    for (int i = 0; i < 40; i++) pending_requests.push_back(make_req(CmdAlloc, 0, 1));
    wait_drained();

    // random phases: restore the pool, then carve fixed slices and churn
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 54;
        recv_idle_pct = 6;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_fit_mode(ph[0]);
      for (int i = 0; i < 64; i++)
        pending_requests.push_back(make_req(CmdRelease, i * 512, 512));
      pending_requests.push_back(make_req(CmdRelease, 32768 - 512, 511));
      held_base.delete();
      held_len.delete();
      for (int i = 0; i < 64; i++)
        pending_requests.push_back(make_req(CmdAlloc, 0, 512));
      queue_pieces(63, 512);
      queue_random(450);
      wait_drained();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
